@@ design/fsort_pkg.sv @@
// ----------------------------------------------------------------------------
// fsort_pkg
// Beat types and shared constants for the frequency sort block.
// ----------------------------------------------------------------------------
package fsort_pkg;

    localparam int VAL_W = 32;
    localparam int CNT_W = 7;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    is_last;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic                    last_out;
        logic                    overflowed;
    } t_out_item;

    typedef struct packed {
        logic match;
        logic greater;
    } t_cmp_res;

endpackage

@@ design/frequency_sort.sv @@
// ----------------------------------------------------------------------------
// frequency_sort
// Collects a set of values, then replays them grouped by value, most frequent
// group first, ties in order of first appearance.
//
//   channel  direction  handshake                   beat
//   in       input      i_in_valid / o_in_ready     t_in_item
//   out      output     o_out_valid / i_out_ready   t_out_item
//
// An input beat makes one serial pass over the D distinct values held so far
// through the table's registered read port, cut short on a match. A beat
// arriving at capacity is dropped, and the set is marked as overflowed.
// Each output group costs a ranking pass over the table, then one beat per
// element, each beat moving whenever the sink is ready.
// Reset is synchronous; no clearing pass is needed. The input is not ready
// while a set is being replayed; output stalls simply hold the beat.
// ----------------------------------------------------------------------------
module frequency_sort #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  fsort_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output fsort_pkg::t_out_item  o_out_data
);
    import fsort_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SCAN,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [CW-1:0]           r_used;
    logic [CW-1:0]           r_held;
    logic [CW-1:0]           r_left;
    logic [CW-1:0]           r_idx;
    logic                    r_ovf;
    logic [MAX_ITEMS-1:0]    r_emit;
    logic                    r_chk;
    logic [AW-1:0]           r_chk_idx;
    logic                    r_found;
    logic [AW-1:0]           r_best_idx;
    logic [CNT_W-1:0]        r_best_cnt;
    logic signed [VAL_W-1:0] r_best_val;
    logic [CNT_W-1:0]        r_rem;
    logic signed [VAL_W-1:0] r_value;
    logic                    r_last;

    logic [AW-1:0]           rd_addr;
    logic signed [VAL_W-1:0] rd_value;
    logic [CNT_W-1:0]        rd_count;
    logic                    we;
    logic [AW-1:0]           waddr;
    logic [CNT_W-1:0]        wcount;
    t_cmp_res                cmp;
    logic                    issue;
    logic                    pass_done;
    logic                    hit;
    logic                    take;

    fsort_table #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_table (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wvalue (r_value),
        .i_wcount (wcount),
        .i_raddr  (rd_addr),
        .o_rvalue (rd_value),
        .o_rcount (rd_count)
    );

    fsort_cmp u_cmp (
        .i_value_a (rd_value),
        .i_value_b (r_value),
        .i_count_a (rd_count),
        .i_count_b (r_best_cnt),
        .o_res     (cmp)
    );

    always_comb begin
        issue     = (r_idx < r_used);
        rd_addr   = issue ? r_idx[AW-1:0] : '0;
        pass_done = !r_chk && !issue;
        hit       = r_chk && cmp.match;
        take      = r_chk && !r_emit[r_chk_idx] && (!r_found || cmp.greater);
        we        = 1'b0;
        waddr     = r_chk_idx;
        wcount    = rd_count + CNT_W'(1);
        if (r_state == S_SEARCH) begin
            if (hit) begin
                we = 1'b1;
            end else if (pass_done) begin
                we     = 1'b1;
                waddr  = r_used[AW-1:0];
                wcount = CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_held  <= '0;
            r_left  <= '0;
            r_idx   <= '0;
            r_ovf   <= 1'b0;
            r_emit  <= '0;
            r_chk   <= 1'b0;
            r_found <= 1'b0;
            r_rem   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_chk   <= 1'b0;
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    if (i_in_valid) begin
                        r_value <= i_in_data.value;
                        r_last  <= i_in_data.is_last;
                        if (r_held >= CW'(MAX_ITEMS)) begin
                            r_ovf <= 1'b1;
                            if (i_in_data.is_last) begin
                                r_left  <= r_held;
                                r_state <= S_SCAN;
                            end
                        end else begin
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    r_chk     <= issue;
                    r_chk_idx <= rd_addr;
                    if (issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (hit || pass_done) begin
                        r_held <= r_held + CW'(1);
                        if (!hit) begin
                            r_used <= r_used + CW'(1);
                        end
                        r_chk <= 1'b0;
                        r_idx <= '0;
                        if (r_last) begin
                            r_left  <= r_held + CW'(1);
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SCAN: begin
                    r_chk     <= issue;
                    r_chk_idx <= rd_addr;
                    if (issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (take) begin
                        r_found    <= 1'b1;
                        r_best_idx <= r_chk_idx;
                        r_best_cnt <= rd_count;
                        r_best_val <= rd_value;
                    end
                    if (pass_done) begin
                        r_emit[r_best_idx] <= 1'b1;
                        r_rem   <= r_best_cnt;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_left <= r_left - CW'(1);
                        r_rem  <= r_rem - CW'(1);
                        if (r_left == CW'(1)) begin
                            r_used  <= '0;
                            r_held  <= '0;
                            r_ovf   <= 1'b0;
                            r_emit  <= '0;
                            r_state <= S_IDLE;
                        end else if (r_rem == CNT_W'(1)) begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready              = (r_state == S_IDLE);
    assign o_out_valid             = (r_state == S_OUT);
    assign o_out_data.sorted_value = r_best_val;
    assign o_out_data.last_out     = (r_left == CW'(1));
    assign o_out_data.overflowed   = r_ovf;

    // sets are never taken in while one is being replayed
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready during replay");

    a_held_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held <= CW'(MAX_ITEMS)) && (r_used <= r_held))
        else $error("occupancy out of range");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last_out)
        |=> (r_held == '0) && (r_used == '0) && (r_emit == '0) && !r_ovf)
        else $error("set state not cleared after final beat");

    a_group_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_rem != '0) && (r_left != '0))
        else $error("beat presented with nothing left to send");

endmodule

@@ design/fsort_table.sv @@
// ----------------------------------------------------------------------------
// fsort_table
// Distinct value and occurrence count store, one write and one registered read.
// ----------------------------------------------------------------------------
module fsort_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [AW-1:0]                      i_waddr,
    input  logic signed [fsort_pkg::VAL_W-1:0] i_wvalue,
    input  logic [fsort_pkg::CNT_W-1:0]        i_wcount,
    input  logic [AW-1:0]                      i_raddr,
    output logic signed [fsort_pkg::VAL_W-1:0] o_rvalue,
    output logic [fsort_pkg::CNT_W-1:0]        o_rcount
);
    import fsort_pkg::*;

    logic signed [VAL_W-1:0] r_val_mem [DEPTH];
    logic [CNT_W-1:0]        r_cnt_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_val_mem[i_waddr] <= i_wvalue;
            r_cnt_mem[i_waddr] <= i_wcount;
        end
        o_rvalue <= r_val_mem[i_raddr];
        o_rcount <= r_cnt_mem[i_raddr];
    end

endmodule

@@ design/fsort_cmp.sv @@
// ----------------------------------------------------------------------------
// fsort_cmp
// Shared compare unit: value equality for lookup, count magnitude for ranking.
// ----------------------------------------------------------------------------
module fsort_cmp (
    input  logic signed [fsort_pkg::VAL_W-1:0] i_value_a,
    input  logic signed [fsort_pkg::VAL_W-1:0] i_value_b,
    input  logic [fsort_pkg::CNT_W-1:0]        i_count_a,
    input  logic [fsort_pkg::CNT_W-1:0]        i_count_b,
    output fsort_pkg::t_cmp_res                o_res
);
    import fsort_pkg::*;

    assign o_res.match   = (i_value_a == i_value_b);
    assign o_res.greater = (i_count_a > i_count_b);

endmodule
